// ----- design/see_pkg.sv -----
package see_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned MAX_EXP = 4;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned LEN_W   = 16;

    localparam logic CFG_HEX_MODE   = 1'b0;
    localparam logic CFG_MAX_LENGTH = 1'b1;

    typedef struct packed {
        logic [CHAR_W-1:0] byte_in;
        logic              end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              last_char;
    } out_item_t;

    // one classified byte: up to four characters, index of the final one, string end
    typedef struct packed {
        logic [MAX_EXP-1:0][CHAR_W-1:0] chars;
        logic [1:0]                     last_idx;
        logic                           eos;
    } exp_item_t;

endpackage

// ----- design/see_front.sv -----
module see_front (
    input  see_pkg::in_item_t  item,
    input  logic               hex_mode,
    output see_pkg::exp_item_t exp
);

    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_X      = 8'h78;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10) begin
            d = 8'h30 + {4'd0, nib};
        end else begin
            d = 8'h57 + {4'd0, nib};
        end
        return d;
    endfunction

    logic [7:0] b;
    logic [7:0] esc;
    logic       is_esc;

    assign b = item.byte_in;

    always_comb begin
        is_esc = 1'b1;
        unique case (b)
            8'h00:   esc = 8'h30;
            8'h07:   esc = 8'h61;
            8'h08:   esc = 8'h62;
            8'h09:   esc = 8'h74;
            8'h0a:   esc = 8'h6e;
            8'h0b:   esc = 8'h76;
            8'h0c:   esc = 8'h66;
            8'h0d:   esc = 8'h72;
            8'h1b:   esc = 8'h65;
            8'h22:   esc = 8'h22;
            8'h27:   esc = 8'h27;
            8'h5c:   esc = 8'h5c;
            default: begin
                esc    = b;
                is_esc = 1'b0;
            end
        endcase
    end

    always_comb begin
        exp.eos      = item.end_of_string;
        exp.chars[2] = hex_digit(b[7:4]);
        exp.chars[3] = hex_digit(b[3:0]);
        if (hex_mode && (b == 8'h00 || b[7])) begin
            exp.chars[0] = CH_BSLASH;
            exp.chars[1] = CH_X;
            exp.last_idx = 2'd3;
        end else if (is_esc) begin
            exp.chars[0] = CH_BSLASH;
            exp.chars[1] = esc;
            exp.last_idx = 2'd1;
        end else begin
            exp.chars[0] = b;
            exp.chars[1] = b;
            exp.last_idx = 2'd0;
        end
    end

endmodule

// ----- design/see_fifo.sv -----
module see_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  see_pkg::exp_item_t wr_data,
    output logic               full,
    input  logic               rd_en,
    output logic               rd_valid,
    output see_pkg::exp_item_t rd_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    see_pkg::exp_item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/see_back.sv -----
module see_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [see_pkg::LEN_W-1:0]    max_length,
    input  logic                         q_valid,
    input  see_pkg::exp_item_t           q_item,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output see_pkg::out_item_t           m_data
);

    localparam logic [7:0] CH_DOT = 8'h2e;

    logic [see_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        trunc_reg, trunc_next;
    logic                        dots_reg, dots_next;
    logic [1:0]                  dot_cnt_reg, dot_cnt_next;
    logic [1:0]                  idx_reg, idx_next;
    logic                        m_valid_reg, m_valid_next;
    see_pkg::out_item_t          m_data_reg, m_data_next;

    logic load_ok;
    logic limit_hit;

    assign load_ok   = !m_valid_reg || m_ready;
    assign limit_hit = (max_length != '0) &&
                       (count_reg >= {1'b0, max_length});

    always_comb begin
        count_next   = count_reg;
        trunc_next   = trunc_reg;
        dots_next    = dots_reg;
        dot_cnt_next = dot_cnt_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        q_pop        = 1'b0;
        if (q_valid) begin
            if (trunc_reg) begin
                // rest of a truncated string is dropped
                q_pop = 1'b1;
                if (q_item.eos) begin
                    count_next = '0;
                    trunc_next = 1'b0;
                end
            end else if (load_ok) begin
                m_valid_next         = 1'b1;
                m_data_next.last_char = 1'b0;
                if (dots_reg) begin
                    m_data_next.char_out = CH_DOT;
                    if (dot_cnt_reg == 2'd2) begin
                        m_data_next.last_char = 1'b1;
                        dots_next    = 1'b0;
                        dot_cnt_next = '0;
                        idx_next     = '0;
                        q_pop        = 1'b1;
                        if (q_item.eos) begin
                            count_next = '0;
                        end else begin
                            trunc_next = 1'b1;
                        end
                    end else begin
                        dot_cnt_next = dot_cnt_reg + 2'd1;
                    end
                end else if (limit_hit) begin
                    m_data_next.char_out = CH_DOT;
                    dots_next    = 1'b1;
                    dot_cnt_next = 2'd1;
                end else begin
                    m_data_next.char_out = q_item.chars[idx_reg];
                    if (count_reg != '1) begin
                        count_next = count_reg + 1'b1;
                    end
                    if (idx_reg == q_item.last_idx) begin
                        m_data_next.last_char = q_item.eos;
                        idx_next = '0;
                        q_pop    = 1'b1;
                        if (q_item.eos) begin
                            count_next = '0;
                        end
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            trunc_reg   <= 1'b0;
            dots_reg    <= 1'b0;
            dot_cnt_reg <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            trunc_reg   <= trunc_next;
            dots_reg    <= dots_next;
            dot_cnt_reg <= dot_cnt_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- design/string_escape_encoder_core.sv -----
// An accepted byte is written into the item queue; the back end registers its characters into m_data.
// Throughput: one character per cycle while m_ready is high; a byte causes 1 to 6
// characters (at most 4 escape characters, or 3 plus the 3-dot ellipsis), none when dropped.
// The front end accepts a byte per cycle while the item queue has room.
// Reset (aresetn low, synchronous) clears the queue, the length count, the
// truncation state and both configuration registers.
module string_escape_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [see_pkg::LEN_W-1:0]   cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  see_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output see_pkg::out_item_t          m_data
);

    logic                      hex_mode_reg;
    logic [see_pkg::LEN_W-1:0] max_length_reg;
    see_pkg::exp_item_t        front_item;
    see_pkg::exp_item_t        q_item;
    logic                      q_full;
    logic                      q_valid;
    logic                      q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hex_mode_reg   <= 1'b0;
            max_length_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                see_pkg::CFG_HEX_MODE:   hex_mode_reg   <= cfg_wdata[0];
                see_pkg::CFG_MAX_LENGTH: max_length_reg <= cfg_wdata;
                default:                 hex_mode_reg   <= hex_mode_reg;
            endcase
        end
    end

    assign s_ready = !q_full;

    see_front u_front (
        .item     (s_data),
        .hex_mode (hex_mode_reg),
        .exp      (front_item)
    );

    see_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (s_valid),
        .wr_data  (front_item),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_item)
    );

    see_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .max_length (max_length_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
